// ----- hw/rtl/p1305_pkg.sv -----
`default_nettype none
package p1305_pkg;

  localparam int unsigned A_DIGITS = 5;
  localparam int unsigned R_DIGITS = 4;
  localparam int unsigned P_WORDS  = 9;

  localparam logic [127:0] R_CLAMP = 128'h0ffffffc0ffffffc0ffffffc0fffffff;

  typedef struct packed {
    logic       load;
    logic       mul;
    logic [2:0] a_idx;
    logic [1:0] r_idx;
    logic       red1;
    logic       red2;
    logic       red3;
    logic       red4;
    logic       fin;
  } cmd_t;

endpackage
`default_nettype wire

// ----- hw/rtl/p1305_dp.sv -----
`default_nettype none
module p1305_dp (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire p1305_pkg::cmd_t    cmd,
  input  wire logic [63:0]        data_low,
  input  wire logic [63:0]        data_high,
  input  wire logic [4:0]         byte_count,
  input  wire logic [127:0]       key_r,
  input  wire logic [127:0]       key_s,
  output logic [63:0]             tag_low,
  output logic [63:0]             tag_high
);

  logic [159:0] a_r;
  logic [31:0]  prod_r [p1305_pkg::P_WORDS];
  logic [31:0]  carry_r;
  logic [129:0] acc_r;
  logic [127:0] f_r;
  logic [130:0] v_r;
  logic [127:0] tag_r;

  logic [127:0] msg;
  logic [4:0]   cnt_eff;
  logic [135:0] blk;
  logic [127:0] r_cl;
  logic [31:0]  a_dig;
  logic [31:0]  r_dig;
  logic [3:0]   widx;
  logic [31:0]  prev;
  logic [63:0]  t;
  logic [287:0] pfull;
  logic [130:0] g;

  assign msg = {data_high, data_low};

  always_comb begin
    cnt_eff = (byte_count > 5'd16) ? 5'd16 : byte_count;
    for (int b = 0; b < 17; b++) begin
      if (b < 16 && 5'(b) < cnt_eff) begin
        blk[8*b +: 8] = msg[8*b +: 8];
      end else if (5'(b) == cnt_eff) begin
        blk[8*b +: 8] = 8'h01;
      end else begin
        blk[8*b +: 8] = 8'h00;
      end
    end
  end

  assign r_cl  = key_r & p1305_pkg::R_CLAMP;
  assign a_dig = a_r[32*cmd.a_idx +: 32];
  assign r_dig = r_cl[32*cmd.r_idx +: 32];
  assign widx  = {1'b0, cmd.a_idx} + {2'b00, cmd.r_idx};
  assign prev  = (cmd.r_idx == 2'd0) ? 32'd0 : prod_r[widx];
  assign t     = 64'(a_dig) * 64'(r_dig) + {32'd0, prev}
               + {32'd0, (cmd.a_idx == 3'd0) ? 32'd0 : carry_r};

  always_comb begin
    for (int k = 0; k < p1305_pkg::P_WORDS; k++) begin
      pfull[32*k +: 32] = prod_r[k];
    end
  end

  assign g = v_r + 131'd5;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a_r <= {29'd0, {1'b0, acc_r} + {2'b00, blk[128:0]}};
    end
    if (cmd.mul) begin
      prod_r[widx] <= t[31:0];
      carry_r      <= t[63:32];
      if (cmd.a_idx == 3'(p1305_pkg::A_DIGITS - 1)) begin
        prod_r[widx + 4'd1] <= t[63:32];
      end
    end
    if (cmd.red1) begin
      f_r <= {2'b00, pfull[255:130]} + {1'b0, pfull[254:130], 2'b00};
    end
    if (cmd.red2) begin
      v_r <= {1'b0, pfull[129:0]} + {3'b000, f_r};
    end
    if (cmd.red3) begin
      v_r <= {1'b0, v_r[129:0]} + (v_r[130] ? 131'd5 : 131'd0);
    end
    if (cmd.fin) begin
      tag_r <= acc_r[127:0] + key_s;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (cmd.red4) begin
      acc_r <= g[130] ? g[129:0] : v_r[129:0];
    end else if (cmd.fin) begin
      acc_r <= '0;
    end
  end

  assign tag_low  = tag_r[63:0];
  assign tag_high = tag_r[127:64];

endmodule
`default_nettype wire

// ----- hw/rtl/p1305_ctrl.sv -----
`default_nettype none
module p1305_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire logic [4:0]      in_byte_count,
  input  wire logic            in_last_block,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output p1305_pkg::cmd_t      cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_RED1 = 3'd2;
  localparam logic [2:0] S_RED2 = 3'd3;
  localparam logic [2:0] S_RED3 = 3'd4;
  localparam logic [2:0] S_RED4 = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic [2:0] a_idx_r, a_idx_nxt;
  logic [1:0] r_idx_r, r_idx_nxt;
  logic       last_r, last_nxt;
  logic       ovld_r, ovld_nxt;
  logic       accept;
  logic       fin_go;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && (state_r == S_IDLE);
  assign out_valid = ovld_r;
  assign fin_go    = (state_r == S_FIN) && (!ovld_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    a_idx_nxt = a_idx_r;
    r_idx_nxt = r_idx_r;
    last_nxt  = last_r;
    ovld_nxt  = ovld_r && out_stall;
    cmd       = '0;
    cmd.a_idx = a_idx_r;
    cmd.r_idx = r_idx_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          last_nxt  = in_last_block;
          a_idx_nxt = '0;
          r_idx_nxt = '0;
          if (in_byte_count != 5'd0) begin
            cmd.load  = 1'b1;
            state_nxt = S_MUL;
          end else if (in_last_block) begin
            state_nxt = S_FIN;
          end
        end
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        if (a_idx_r == 3'(p1305_pkg::A_DIGITS - 1)) begin
          a_idx_nxt = '0;
          r_idx_nxt = r_idx_r + 2'd1;
          if (r_idx_r == 2'(p1305_pkg::R_DIGITS - 1)) begin
            state_nxt = S_RED1;
          end
        end else begin
          a_idx_nxt = a_idx_r + 3'd1;
        end
      end
      S_RED1: begin
        cmd.red1  = 1'b1;
        state_nxt = S_RED2;
      end
      S_RED2: begin
        cmd.red2  = 1'b1;
        state_nxt = S_RED3;
      end
      S_RED3: begin
        cmd.red3  = 1'b1;
        state_nxt = S_RED4;
      end
      S_RED4: begin
        cmd.red4  = 1'b1;
        state_nxt = last_r ? S_FIN : S_IDLE;
      end
      S_FIN: begin
        if (fin_go) begin
          cmd.fin   = 1'b1;
          ovld_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      a_idx_r <= '0;
      r_idx_r <= '0;
      last_r  <= 1'b0;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      a_idx_r <= a_idx_nxt;
      r_idx_r <= r_idx_nxt;
      last_r  <= last_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/poly1305_mac.sv -----
`default_nettype none
// Channel   Direction  Handshake          Payload
// in        input      in_valid/in_stall  in_data_low, in_data_high, in_byte_count,
//                                         in_last_block
// out       output     out_valid/out_stall out_tag_low, out_tag_high
// cfg       input      APB write/read     key_r_low, key_r_high, key_s_low, key_s_high
//
// A nonempty block is loaded, then runs once per digit pair through the shared
// 32x32 multiplier (five accumulator digits by four key digits), and then takes four
// reduction steps. Finishing a tag is one more step, held back while a tag is stalled.
// Reset clears the accumulator, the keys and all control state.
// A tag waits in the output register under out_stall while the next block runs.
module poly1305_mac (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [63:0] in_data_low,
  input  wire logic [63:0] in_data_high,
  input  wire logic [4:0]  in_byte_count,
  input  wire logic        in_last_block,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      out_tag_low,
  output logic [63:0]      out_tag_high,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);

  logic [63:0]     key_r_r [4];
  p1305_pkg::cmd_t cmd;

  assign pready = 1'b1;
  assign prdata = key_r_r[paddr[4:3]];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 4; k++) begin
        key_r_r[k] <= '0;
      end
    end else if (psel && penable && pwrite) begin
      key_r_r[paddr[4:3]] <= pwdata;
    end
  end

  p1305_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_byte_count (in_byte_count),
    .in_last_block (in_last_block),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .cmd           (cmd)
  );

  p1305_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .data_low   (in_data_low),
    .data_high  (in_data_high),
    .byte_count (in_byte_count),
    .key_r      ({key_r_r[1], key_r_r[0]}),
    .key_s      ({key_r_r[3], key_r_r[2]}),
    .tag_low    (out_tag_low),
    .tag_high   (out_tag_high)
  );

endmodule
`default_nettype wire
